// ===== hdl/lrs_pkg.sv =====
// Package for the stereo linear resampler.
// Holds the sequencer state type, the multiplier control struct and fixed constants.
// No dependencies.
package lrs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 23;
    localparam int PHASE_W  = 24;
    localparam int CNT_W    = 7;
    localparam int PROD_W   = 32;

    localparam logic [PHASE_W-1:0] ONE_UNIT    = 24'h01_0000;
    localparam logic [CNT_W-1:0]   MAX_RUN     = 7'd64;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 23'd97391;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_L,
        S_MUL_R,
        S_EMIT,
        S_WAIT,
        S_FINISH
    } lrs_state_t;

    typedef struct packed {
        logic en;
        logic sel_right;
    } lrs_mul_ctl_t;

endpackage

// ===== hdl/lrs_mul_unit.sv =====
// Shared interpolation unit: one registered 17x17 multiply and an add.
// Computes prev + ((cur - prev) * frac >>> 16) for the selected channel.
// Depends on lrs_pkg.
module lrs_mul_unit (
    input  logic                           aclk,
    input  lrs_pkg::lrs_mul_ctl_t          ctl,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] prev_l,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] prev_r,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] cur_l,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] cur_r,
    input  logic [15:0]                    frac,
    output logic signed [lrs_pkg::SAMPLE_W-1:0] result
);

    logic signed [lrs_pkg::SAMPLE_W-1:0] prev_sel;
    logic signed [lrs_pkg::SAMPLE_W-1:0] cur_sel;
    logic signed [16:0]                  diff;
    logic signed [33:0]                  prod_full;
    logic [lrs_pkg::PROD_W-1:0]          prod_reg;
    logic signed [lrs_pkg::SAMPLE_W-1:0] prev_reg;

    always_comb begin
        prev_sel  = ctl.sel_right ? prev_r : prev_l;
        cur_sel   = ctl.sel_right ? cur_r : cur_l;
        diff      = 17'(signed'({cur_sel[15], cur_sel})) - 17'(signed'({prev_sel[15], prev_sel}));
        prod_full = diff * signed'({1'b0, frac});
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            prod_reg <= prod_full[lrs_pkg::PROD_W-1:0];
            prev_reg <= prev_sel;
        end
    end

    assign result = prev_reg + signed'(prod_reg[31:16]);

endmodule

// ===== hdl/linear_resampler_stereo_core.sv =====
// Sequencing: a priming beat is stored as the previous frame and yields no result; for
// any other input beat each result steps through CHECK, MUL_L and MUL_R (the left and
// right passes through the shared multiplier), EMIT and WAIT, which holds until taken.
// A last CHECK and FINISH end the run; no new input beat is taken before IDLE.
// Reset (aresetn low, synchronous) clears the previous frame, the phase and the primed flag,
// and loads the step register with 97391.
module linear_resampler_stereo_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [22:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_left_in,
    input  logic signed [15:0] s_right_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_left_out,
    output logic signed [15:0] m_right_out,
    output logic        m_last_of_run
);

    lrs_pkg::lrs_state_t state_reg, state_next;
    lrs_pkg::lrs_mul_ctl_t mul_ctl;

    logic [lrs_pkg::STEP_W-1:0]  step_reg;
    logic [lrs_pkg::PHASE_W-1:0] phase_reg;
    logic [lrs_pkg::CNT_W-1:0]   cnt_reg;
    logic                        primed_reg;
    logic                        last_reg;
    logic signed [15:0]          prev_l_reg, prev_r_reg;
    logic signed [15:0]          cur_l_reg, cur_r_reg;
    logic signed [15:0]          left_out_reg, right_out_reg;
    logic signed [15:0]          mul_result;
    logic                        run_more;

    assign run_more = (phase_reg < lrs_pkg::ONE_UNIT) && (cnt_reg < lrs_pkg::MAX_RUN);

    lrs_mul_unit u_mul (
        .aclk   (aclk),
        .ctl    (mul_ctl),
        .prev_l (prev_l_reg),
        .prev_r (prev_r_reg),
        .cur_l  (cur_l_reg),
        .cur_r  (cur_r_reg),
        .frac   (phase_reg[15:0]),
        .result (mul_result)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lrs_pkg::S_IDLE: begin
                if (s_valid && primed_reg) begin
                    state_next = lrs_pkg::S_CHECK;
                end
            end
            lrs_pkg::S_CHECK: begin
                state_next = run_more ? lrs_pkg::S_MUL_L : lrs_pkg::S_FINISH;
            end
            lrs_pkg::S_MUL_L: state_next = lrs_pkg::S_MUL_R;
            lrs_pkg::S_MUL_R: state_next = lrs_pkg::S_EMIT;
            lrs_pkg::S_EMIT:  state_next = lrs_pkg::S_WAIT;
            lrs_pkg::S_WAIT: begin
                if (m_ready) begin
                    state_next = lrs_pkg::S_CHECK;
                end
            end
            lrs_pkg::S_FINISH: state_next = lrs_pkg::S_IDLE;
            default: state_next = lrs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready           = 1'b0;
        m_valid           = 1'b0;
        mul_ctl.en        = 1'b0;
        mul_ctl.sel_right = 1'b0;
        case (state_reg)
            lrs_pkg::S_IDLE:  s_ready = 1'b1;
            lrs_pkg::S_MUL_L: mul_ctl.en = 1'b1;
            lrs_pkg::S_MUL_R: begin
                mul_ctl.en        = 1'b1;
                mul_ctl.sel_right = 1'b1;
            end
            lrs_pkg::S_WAIT:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_left_out    = left_out_reg;
    assign m_right_out   = right_out_reg;
    assign m_last_of_run = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lrs_pkg::S_IDLE;
            step_reg   <= lrs_pkg::STEP_RESET;
            phase_reg  <= '0;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
            last_reg   <= 1'b0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            case (state_reg)
                lrs_pkg::S_IDLE: begin
                    if (s_valid) begin
                        cnt_reg <= '0;
                        if (primed_reg) begin
                            cur_l_reg <= s_left_in;
                            cur_r_reg <= s_right_in;
                        end else begin
                            prev_l_reg <= s_left_in;
                            prev_r_reg <= s_right_in;
                            phase_reg  <= '0;
                            primed_reg <= 1'b1;
                        end
                    end
                end
                lrs_pkg::S_MUL_R: begin
                    left_out_reg <= mul_result;
                    phase_reg    <= phase_reg + lrs_pkg::PHASE_W'(step_reg);
                    cnt_reg      <= cnt_reg + 1'b1;
                end
                lrs_pkg::S_EMIT: begin
                    right_out_reg <= mul_result;
                    last_reg      <= (phase_reg >= lrs_pkg::ONE_UNIT)
                                     || (cnt_reg == lrs_pkg::MAX_RUN);
                end
                lrs_pkg::S_FINISH: begin
                    if (phase_reg < lrs_pkg::ONE_UNIT) begin
                        phase_reg <= '0;
                    end else begin
                        phase_reg <= phase_reg - lrs_pkg::ONE_UNIT;
                    end
                    prev_l_reg <= cur_l_reg;
                    prev_r_reg <= cur_r_reg;
                end
                default: begin
                    last_reg <= last_reg;
                end
            endcase
        end
    end

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result handshakes active together");

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= lrs_pkg::MAX_RUN)
        else $error("run count above cap");

    a_more_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> (phase_reg < lrs_pkg::ONE_UNIT))
        else $error("non-final beat with phase past the interval");

    a_phase_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lrs_pkg::S_FINISH) |=> (phase_reg[lrs_pkg::PHASE_W-1] == 1'b0))
        else $error("phase overflow after wrap");

endmodule

// ===== tb/tb_linear_resampler_stereo_core.sv =====
// Self-checking testbench for linear_resampler_stereo_core: random bursty source beats,
// a patterned sink with one long hold-off, and an in-bench resampler predictor.
// Depends on lrs_pkg and linear_resampler_stereo_core.
module tb_linear_resampler_stereo_core;

    localparam int unsigned PHASE_ONE    = 65536;
    localparam int          RUN_CAP      = 64;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          STALL_LIMIT  = 2000;

    typedef struct {
        logic signed [15:0] lsample;
        logic signed [15:0] rsample;
    } src_frame_t;

    typedef struct {
        logic signed [15:0] lsample;
        logic signed [15:0] rsample;
        logic               last_flag;
    } out_frame_t;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [lrs_pkg::STEP_W-1:0] cfg_wr_data = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic signed [15:0]       s_left_in     = '0;
    logic signed [15:0]       s_right_in    = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [15:0]       m_left_out;
    logic signed [15:0]       m_right_out;
    logic                     m_last_of_run;

    src_frame_t src_frames[$];
    out_frame_t expected_frames[$];

    logic signed [15:0]         hist_left;
    logic signed [15:0]         hist_right;
    int unsigned                phase_acc;
    bit                         primed_flag;
    logic [lrs_pkg::STEP_W-1:0] step_cfg;

    int mismatch_count = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int seg_left       = 0;
    logic [7:0] seg_mask = 8'hFF;
    logic [2:0] seg_pos  = '0;
    int burst_left     = 1;
    int gap_left       = 0;
    int idle_cycles    = 0;

    linear_resampler_stereo_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_in     (s_left_in),
        .s_right_in    (s_right_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_out    (m_left_out),
        .m_right_out   (m_right_out),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic signed [15:0] lerp16(input logic signed [15:0] a,
                                                  input logic signed [15:0] b,
                                                  input logic [15:0] frac);
        longint delta;
        longint sum;
        delta = longint'(b) - longint'(a);
        sum   = longint'(a) + ((delta * longint'(frac)) >>> 16);
        return sum[15:0];
    endfunction

    task automatic resample_frame(input logic signed [15:0] cur_l,
                                  input logic signed [15:0] cur_r);
        int          n;
        int unsigned next_phase;
        out_frame_t  res;
        n = 0;
        if (!primed_flag) begin
            phase_acc   = 0;
            primed_flag = 1'b1;
        end else begin
            while (phase_acc < PHASE_ONE && n < RUN_CAP) begin
                next_phase    = phase_acc + step_cfg;
                res.lsample   = lerp16(hist_left, cur_l, phase_acc[15:0]);
                res.rsample   = lerp16(hist_right, cur_r, phase_acc[15:0]);
                res.last_flag = (next_phase >= PHASE_ONE) || (n == RUN_CAP - 1);
                expected_frames.push_back(res);
                n++;
                phase_acc = next_phase;
            end
            if (phase_acc < PHASE_ONE) begin
                phase_acc = 0;
            end else begin
                phase_acc = (phase_acc - PHASE_ONE) & 32'h7F_FFFF;
            end
        end
        hist_left  = cur_l;
        hist_right = cur_r;
    endtask

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic logic signed [15:0] rand_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 7);
        case (pick)
            0: v = -32768;
            1: v = 32767;
            2: v = int'($urandom_range(0, 64)) - 32;
            default: v = int'($urandom);
        endcase
        return v[15:0];
    endfunction

    task automatic queue_frame(input logic signed [15:0] l, input logic signed [15:0] r);
        src_frame_t f;
        f.lsample = l;
        f.rsample = r;
        src_frames.push_back(f);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (src_frames.size() != 0 || s_valid || expected_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_step(input logic [lrs_pkg::STEP_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        step_cfg = value;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [lrs_pkg::STEP_W-1:0] value, input int count,
                             input bit long_hold);
        write_step(value);
        if (long_hold) begin
            hold_requests++;
        end
        repeat (count) queue_frame(rand_sample(), rand_sample());
    endtask

    // Source side: bursts of beats separated by random gaps.
    always @(posedge aclk) begin : drive_source
        src_frame_t frame;
        if (aresetn && (!s_valid || s_ready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (src_frames.size() > 0) begin
                frame = src_frames.pop_front();
                s_valid    <= 1'b1;
                s_left_in  <= frame.lsample;
                s_right_in <= frame.rsample;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Sink side: a rotating ready mask per segment, plus a long hold-off on request.
    always @(posedge aclk) begin : drive_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(4, 64);
                seg_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
                m_ready  <= 1'b1;
            end else begin
                seg_left <= seg_left - 1;
                m_ready  <= seg_mask[seg_pos];
            end
            seg_pos <= seg_pos + 3'd1;
        end
    end

    // Results are checked before the accepted source beat is predicted.
    always @(posedge aclk) begin : check_results
        out_frame_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    note_error($sformatf("unexpected beat: left %0d right %0d last %0b",
                                         m_left_out, m_right_out, m_last_of_run));
                end else begin
                    want = expected_frames.pop_front();
                    if (m_left_out !== want.lsample) begin
                        note_error($sformatf("left_out: expected %0d, got %0d",
                                             want.lsample, m_left_out));
                    end
                    if (m_right_out !== want.rsample) begin
                        note_error($sformatf("right_out: expected %0d, got %0d",
                                             want.rsample, m_right_out));
                    end
                    if (m_last_of_run !== want.last_flag) begin
                        note_error($sformatf("last_of_run: expected %0b, got %0b",
                                             want.last_flag, m_last_of_run));
                    end
                end
            end
            if (s_valid && s_ready) begin
                resample_frame(s_left_in, s_right_in);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        hist_left   = '0;
        hist_right  = '0;
        phase_acc   = 0;
        primed_flag = 1'b0;
        step_cfg    = lrs_pkg::STEP_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The first beat only primes the previous frame.
        queue_frame(16'sh8000, 16'sh7FFF);
        queue_frame(16'sh7FFF, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7FFF);
        queue_frame(16'sh0000, 16'sh0000);
        queue_frame(16'shFFFF, 16'sh0001);
        queue_frame(16'sh8000, 16'sh8000);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh5555, 16'shAAAA);
        queue_frame(16'shAAAA, 16'sh5555);
        queue_frame(16'sh0001, 16'shFFFF);
        queue_frame(16'sh7FFF, 16'sh8000);
        queue_frame(16'sh8000, 16'sh7FFF);
        for (k = 0; k < 6; k++) begin
            queue_frame(rand_sample(), rand_sample());
        end

        run_phase(23'd65536, 25, 1'b0);
        run_phase(23'd1024, 12, 1'b1);

        // Steps below the minimum hit the per-beat run cap.
        write_step(23'd0);
        queue_frame(16'sh8000, 16'sh7FFF);
        queue_frame(16'sh7FFF, 16'sh8000);
        queue_frame(16'sh0000, 16'shFFFF);
        queue_frame(16'shFFFF, 16'sh0000);
        run_phase(23'd500, 3, 1'b0);

        for (k = 0; k < 5; k++) begin
            if (k == 4) begin
                run_phase(23'($urandom_range(1024, 4194304)), 25, 1'b0);
            end else begin
                run_phase(23'($urandom_range(1024, 150000)), 25, 1'b0);
            end
        end

        run_phase(23'd4194304, 25, 1'b0);
        run_phase(23'h7F_FFFF, 20, 1'b0);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
